// File: design/asmscan_pkg.sv
// Shared types and constants of the assembler token scanner.
// Holds the character codes, token kinds, error codes and the scan mode enum.
// Used by asmscan_core, asmscan_fifo and assembler_token_scanner.
package asmscan_pkg;

    localparam int OFFSET_WIDTH_DEF = 24;
    localparam int LINE_WIDTH_DEF   = 20;
    localparam int LENGTH_WIDTH_DEF = 8;
    localparam int VALUE_WIDTH      = 64;
    localparam int KIND_WIDTH       = 4;
    localparam int ERR_WIDTH        = 3;
    localparam int RESULT_DEPTH     = 8;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam logic [4:0] HEX_INVALID = 5'd16;

    localparam logic [KIND_WIDTH-1:0] KIND_END    = 4'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_NEWL   = 4'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_ID     = 4'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_INT    = 4'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_COMMA  = 4'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_HASH   = 4'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_COLON  = 4'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_LPAREN = 4'd7;
    localparam logic [KIND_WIDTH-1:0] KIND_RPAREN = 4'd8;

    localparam logic [ERR_WIDTH-1:0] ERR_NONE     = 3'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_UNKNOWN  = 3'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_DIGIT    = 3'd2;
    localparam logic [ERR_WIDTH-1:0] ERR_NODIGIT  = 3'd3;
    localparam logic [ERR_WIDTH-1:0] ERR_OVERFLOW = 3'd4;

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_IDENT,
        M_ZERO,
        M_NUMBER,
        M_DISCARD
    } t_mode;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_BIN,
        BASE_OCT,
        BASE_HEX
    } t_base;

    typedef struct packed {
        logic first;
        logic second;
    } t_push;

endpackage

// File: design/asmscan_fifo.sv
// Result queue of the assembler token scanner.
// Takes up to two results a cycle and gives one a cycle; uses asmscan_pkg.
module asmscan_fifo #(
    parameter int DATA_WIDTH = 64,
    parameter int DEPTH      = asmscan_pkg::RESULT_DEPTH,
    parameter int CNT_WIDTH  = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  asmscan_pkg::t_push    i_push,
    input  logic [DATA_WIDTH-1:0] i_data0,
    input  logic [DATA_WIDTH-1:0] i_data1,
    input  logic                  i_pop,
    output logic [DATA_WIDTH-1:0] o_head,
    output logic                  o_valid,
    output logic [CNT_WIDTH-1:0]  o_count
);

    localparam int PTR_WIDTH = $clog2(DEPTH);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_WIDTH-1:0]  r_wr;
    logic [PTR_WIDTH-1:0]  r_rd;
    logic [CNT_WIDTH-1:0]  r_count;
    logic [PTR_WIDTH-1:0]  n_wr;
    logic [PTR_WIDTH-1:0]  n_rd;
    logic [CNT_WIDTH-1:0]  n_count;
    logic [PTR_WIDTH-1:0]  wr_next;

    assign wr_next = r_wr + PTR_WIDTH'(1);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.first) begin
            n_wr    = wr_next;
            n_count = n_count + CNT_WIDTH'(1);
        end
        if (i_push.second) begin
            n_wr    = r_wr + PTR_WIDTH'(2);
            n_count = n_count + CNT_WIDTH'(1);
        end
        if (i_pop) begin
            n_rd    = r_rd + PTR_WIDTH'(1);
            n_count = n_count - CNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push.second) begin
            r_mem[wr_next] <= i_data1;
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

// File: design/asmscan_core.sv
// Scanning logic of the assembler token scanner: input register, scan state
// and the two passes that turn one byte into up to two packed results.
// Uses the types and constants of asmscan_pkg.
module asmscan_core #(
    parameter int OFFSET_WIDTH = asmscan_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = asmscan_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = asmscan_pkg::LENGTH_WIDTH_DEF,
    parameter int RES_WIDTH    = asmscan_pkg::KIND_WIDTH + asmscan_pkg::ERR_WIDTH
                                 + asmscan_pkg::VALUE_WIDTH + LINE_WIDTH
                                 + OFFSET_WIDTH + LENGTH_WIDTH + 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [7:0]               i_char_code,
    output logic                     o_busy,
    output asmscan_pkg::t_push       o_push,
    output logic [RES_WIDTH-1:0]     o_res0,
    output logic [RES_WIDTH-1:0]     o_res1
);

    localparam int VW = asmscan_pkg::VALUE_WIDTH;

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_ident_start(input logic [7:0] c);
        return is_alpha(c) || c == asmscan_pkg::CH_UNDER || c == asmscan_pkg::CH_DOT;
    endfunction

    function automatic logic is_prefix(input logic [7:0] c);
        return c inside {8'h62, 8'h42, 8'h6F, 8'h4F, 8'h78, 8'h58};
    endfunction

    function automatic asmscan_pkg::t_base prefix_base(input logic [7:0] c);
        asmscan_pkg::t_base b;
        if (c inside {8'h62, 8'h42}) begin
            b = asmscan_pkg::BASE_BIN;
        end else if (c inside {8'h6F, 8'h4F}) begin
            b = asmscan_pkg::BASE_OCT;
        end else begin
            b = asmscan_pkg::BASE_HEX;
        end
        return b;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (is_digit(c)) begin
            v = {1'b0, c[3:0]};
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = 5'({1'b0, c[3:0]} + 5'd9);
        end else begin
            v = asmscan_pkg::HEX_INVALID;
        end
        return v;
    endfunction

    function automatic logic [4:0] base_limit(input asmscan_pkg::t_base b);
        logic [4:0] v;
        case (b)
            asmscan_pkg::BASE_BIN: v = 5'd2;
            asmscan_pkg::BASE_OCT: v = 5'd8;
            asmscan_pkg::BASE_HEX: v = 5'd16;
            default:               v = 5'd10;
        endcase
        return v;
    endfunction

    logic                      r_valid;
    logic [7:0]                r_char;
    asmscan_pkg::t_mode        r_mode;
    asmscan_pkg::t_base        r_base;
    logic [VW-1:0]             r_acc;
    logic                      r_seen;
    logic [2:0]                r_err;
    logic [LINE_WIDTH-1:0]     r_line;
    logic [OFFSET_WIDTH-1:0]   r_off;
    logic [OFFSET_WIDTH-1:0]   r_tok_off;
    logic [LINE_WIDTH-1:0]     r_tok_line;
    logic [LENGTH_WIDTH-1:0]   r_count;

    asmscan_pkg::t_mode        n_mode;
    asmscan_pkg::t_base        n_base;
    logic [VW-1:0]             n_acc;
    logic                      n_seen;
    logic [2:0]                n_err;
    logic [LINE_WIDTH-1:0]     n_line;
    logic [OFFSET_WIDTH-1:0]   n_off;
    logic [OFFSET_WIDTH-1:0]   n_tok_off;
    logic [LINE_WIDTH-1:0]     n_tok_line;
    logic [LENGTH_WIDTH-1:0]   n_count;

    asmscan_pkg::t_mode        m_mode;
    asmscan_pkg::t_base        m_base;
    logic [VW-1:0]             m_acc;
    logic                      m_seen;
    logic [2:0]                m_err;
    logic [LENGTH_WIDTH-1:0]   m_count;
    logic                      again;

    logic [4:0]                hv;
    logic                      digit_ok;
    logic [VW+3:0]             prod;
    logic [VW+3:0]             sum;
    logic                      acc_ovf;
    logic [LENGTH_WIDTH-1:0]   count_inc;
    logic [LINE_WIDTH-1:0]     line_inc;

    logic                      e0_valid;
    logic [3:0]                e0_kind;
    logic                      e1_valid;
    logic [3:0]                e1_kind;
    logic [2:0]                e1_err;
    logic [LENGTH_WIDTH-1:0]   e1_len;
    logic                      clear;
    logic [RES_WIDTH-2:0]      rec0;
    logic [RES_WIDTH-2:0]      rec1;

    // Multiply-accumulate for one digit; the top four bits flag an overflow.
    assign hv       = hex_value(r_char);
    assign digit_ok = (hv < base_limit(r_base));

    always_comb begin
        case (r_base)
            asmscan_pkg::BASE_BIN: prod = {3'b0, r_acc, 1'b0};
            asmscan_pkg::BASE_OCT: prod = {1'b0, r_acc, 3'b0};
            asmscan_pkg::BASE_HEX: prod = {r_acc, 4'b0};
            default:               prod = {1'b0, r_acc, 3'b0} + {3'b0, r_acc, 1'b0};
        endcase
    end

    assign sum       = prod + (VW + 4)'(hv[3:0]);
    assign acc_ovf   = |sum[VW+3:VW];
    assign count_inc = (&r_count) ? r_count : r_count + LENGTH_WIDTH'(1);
    assign line_inc  = (&r_line) ? r_line : r_line + LINE_WIDTH'(1);

    // First pass: the mode that holds an open token or comment sees the byte.
    always_comb begin
        m_mode   = r_mode;
        m_base   = r_base;
        m_acc    = r_acc;
        m_seen   = r_seen;
        m_err    = r_err;
        m_count  = r_count;
        again    = 1'b0;
        e0_valid = 1'b0;
        e0_kind  = asmscan_pkg::KIND_ID;
        case (r_mode)
            asmscan_pkg::M_COMMENT: begin
                if (r_char == asmscan_pkg::CH_LF || r_char == asmscan_pkg::CH_NUL) begin
                    m_mode = asmscan_pkg::M_IDLE;
                    again  = 1'b1;
                end
            end
            asmscan_pkg::M_IDENT: begin
                if (is_ident_start(r_char) || is_digit(r_char)) begin
                    m_count = count_inc;
                end else begin
                    e0_valid = 1'b1;
                    e0_kind  = asmscan_pkg::KIND_ID;
                    m_mode   = asmscan_pkg::M_IDLE;
                    again    = 1'b1;
                end
            end
            asmscan_pkg::M_ZERO: begin
                if (is_prefix(r_char)) begin
                    m_base  = prefix_base(r_char);
                    m_seen  = 1'b0;
                    m_count = count_inc;
                    m_mode  = asmscan_pkg::M_NUMBER;
                end else if (is_digit(r_char)) begin
                    m_base  = asmscan_pkg::BASE_DEC;
                    m_count = count_inc;
                    m_acc   = VW'(r_char[3:0]);
                    m_mode  = asmscan_pkg::M_NUMBER;
                end else if (is_alpha(r_char)) begin
                    m_err  = asmscan_pkg::ERR_DIGIT;
                    m_mode = asmscan_pkg::M_DISCARD;
                end else begin
                    again = 1'b1;
                    if (r_err == asmscan_pkg::ERR_OVERFLOW) begin
                        m_mode = asmscan_pkg::M_DISCARD;
                    end else begin
                        e0_valid = 1'b1;
                        e0_kind  = asmscan_pkg::KIND_INT;
                        m_mode   = asmscan_pkg::M_IDLE;
                    end
                end
            end
            asmscan_pkg::M_NUMBER: begin
                if (digit_ok) begin
                    m_count = count_inc;
                    m_seen  = 1'b1;
                    if (r_err != asmscan_pkg::ERR_OVERFLOW) begin
                        if (acc_ovf) begin
                            m_err = asmscan_pkg::ERR_OVERFLOW;
                        end else begin
                            m_acc = sum[VW-1:0];
                        end
                    end
                end else if (is_alpha(r_char) || is_digit(r_char)) begin
                    m_err  = asmscan_pkg::ERR_DIGIT;
                    m_mode = asmscan_pkg::M_DISCARD;
                end else if (!r_seen) begin
                    m_err  = asmscan_pkg::ERR_NODIGIT;
                    m_mode = asmscan_pkg::M_DISCARD;
                    again  = 1'b1;
                end else begin
                    again = 1'b1;
                    if (r_err == asmscan_pkg::ERR_OVERFLOW) begin
                        m_mode = asmscan_pkg::M_DISCARD;
                    end else begin
                        e0_valid = 1'b1;
                        e0_kind  = asmscan_pkg::KIND_INT;
                        m_mode   = asmscan_pkg::M_IDLE;
                    end
                end
            end
            default: begin
                again = 1'b1;
            end
        endcase
    end

    // Second pass: the byte is seen between tokens or while a line is discarded.
    always_comb begin
        n_mode     = m_mode;
        n_base     = m_base;
        n_acc      = m_acc;
        n_seen     = m_seen;
        n_err      = m_err;
        n_count    = m_count;
        n_line     = r_line;
        n_tok_off  = r_tok_off;
        n_tok_line = r_tok_line;
        e1_valid   = 1'b0;
        e1_kind    = asmscan_pkg::KIND_END;
        e1_err     = asmscan_pkg::ERR_NONE;
        e1_len     = '0;
        clear      = 1'b0;
        if (again) begin
            if (m_mode == asmscan_pkg::M_DISCARD) begin
                if (r_char == asmscan_pkg::CH_LF) begin
                    e1_valid = 1'b1;
                    e1_kind  = asmscan_pkg::KIND_NEWL;
                    e1_err   = m_err;
                    e1_len   = LENGTH_WIDTH'(1);
                    n_err    = asmscan_pkg::ERR_NONE;
                    n_line   = line_inc;
                    n_mode   = asmscan_pkg::M_IDLE;
                end else if (r_char == asmscan_pkg::CH_NUL) begin
                    e1_valid = 1'b1;
                    e1_kind  = asmscan_pkg::KIND_END;
                    e1_err   = m_err;
                    clear    = 1'b1;
                end
            end else begin
                n_mode = asmscan_pkg::M_IDLE;
                if (r_char == asmscan_pkg::CH_NUL) begin
                    e1_valid = 1'b1;
                    e1_kind  = asmscan_pkg::KIND_END;
                    clear    = 1'b1;
                end else if (r_char inside {asmscan_pkg::CH_SPACE, asmscan_pkg::CH_TAB,
                                            asmscan_pkg::CH_CR}) begin
                    n_mode = asmscan_pkg::M_IDLE;
                end else if (r_char == asmscan_pkg::CH_SEMI) begin
                    n_mode = asmscan_pkg::M_COMMENT;
                end else if (is_ident_start(r_char)) begin
                    n_tok_off  = r_off;
                    n_tok_line = r_line;
                    n_count    = LENGTH_WIDTH'(1);
                    n_mode     = asmscan_pkg::M_IDENT;
                end else if (is_digit(r_char)) begin
                    n_tok_off  = r_off;
                    n_tok_line = r_line;
                    n_count    = LENGTH_WIDTH'(1);
                    n_acc      = VW'(r_char[3:0]);
                    n_base     = asmscan_pkg::BASE_DEC;
                    n_seen     = 1'b1;
                    n_err      = asmscan_pkg::ERR_NONE;
                    n_mode     = (r_char == asmscan_pkg::CH_ZERO) ? asmscan_pkg::M_ZERO
                                                                  : asmscan_pkg::M_NUMBER;
                end else if (r_char == asmscan_pkg::CH_LF) begin
                    e1_valid = 1'b1;
                    e1_kind  = asmscan_pkg::KIND_NEWL;
                    e1_len   = LENGTH_WIDTH'(1);
                    n_line   = line_inc;
                end else if (r_char inside {asmscan_pkg::CH_COMMA, asmscan_pkg::CH_HASH,
                                            asmscan_pkg::CH_COLON, asmscan_pkg::CH_LPAREN,
                                            asmscan_pkg::CH_RPAREN}) begin
                    e1_valid = 1'b1;
                    e1_len   = LENGTH_WIDTH'(1);
                    case (r_char)
                        asmscan_pkg::CH_COMMA:  e1_kind = asmscan_pkg::KIND_COMMA;
                        asmscan_pkg::CH_HASH:   e1_kind = asmscan_pkg::KIND_HASH;
                        asmscan_pkg::CH_COLON:  e1_kind = asmscan_pkg::KIND_COLON;
                        asmscan_pkg::CH_LPAREN: e1_kind = asmscan_pkg::KIND_LPAREN;
                        default:                e1_kind = asmscan_pkg::KIND_RPAREN;
                    endcase
                end else begin
                    n_err  = asmscan_pkg::ERR_UNKNOWN;
                    n_mode = asmscan_pkg::M_DISCARD;
                end
            end
        end
        if (clear) begin
            n_mode     = asmscan_pkg::M_IDLE;
            n_base     = asmscan_pkg::BASE_DEC;
            n_acc      = '0;
            n_seen     = 1'b0;
            n_err      = asmscan_pkg::ERR_NONE;
            n_count    = '0;
            n_line     = LINE_WIDTH'(1);
            n_tok_off  = '0;
            n_tok_line = LINE_WIDTH'(1);
        end
        if (r_char == asmscan_pkg::CH_NUL) begin
            n_off = '0;
        end else if (&r_off) begin
            n_off = r_off;
        end else begin
            n_off = r_off + OFFSET_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_mode     <= asmscan_pkg::M_IDLE;
            r_base     <= asmscan_pkg::BASE_DEC;
            r_acc      <= '0;
            r_seen     <= 1'b0;
            r_err      <= asmscan_pkg::ERR_NONE;
            r_line     <= LINE_WIDTH'(1);
            r_off      <= '0;
            r_tok_off  <= '0;
            r_tok_line <= LINE_WIDTH'(1);
            r_count    <= '0;
        end else begin
            r_valid <= i_accept;
            if (r_valid) begin
                r_mode     <= n_mode;
                r_base     <= n_base;
                r_acc      <= n_acc;
                r_seen     <= n_seen;
                r_err      <= n_err;
                r_line     <= n_line;
                r_off      <= n_off;
                r_tok_off  <= n_tok_off;
                r_tok_line <= n_tok_line;
                r_count    <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_char <= i_char_code;
        end
    end

    assign rec0 = {e0_kind, asmscan_pkg::ERR_NONE,
                   (e0_kind == asmscan_pkg::KIND_INT) ? r_acc : {VW{1'b0}},
                   r_tok_line, r_tok_off, r_count};
    assign rec1 = {e1_kind, e1_err, {VW{1'b0}}, r_line, r_off, e1_len};

    assign o_busy        = r_valid;
    assign o_push.first  = r_valid && (e0_valid || e1_valid);
    assign o_push.second = r_valid && e0_valid && e1_valid;
    assign o_res0        = e0_valid ? {rec0, !e1_valid} : {rec1, 1'b1};
    assign o_res1        = {rec1, 1'b1};

endmodule

// File: design/assembler_token_scanner.sv
// Assembler token scanner: one source byte in per cycle, tokens out in order.
// A taken byte is held in the core's input register, and its results enter the
// queue in the cycle after. Bytes are taken every cycle while the eight-entry
// result queue has room for two more results beyond those in flight; the
// output gives one token a cycle while i_stall is low.
// Synchronous active-low reset empties the queue and starts a new text at line 1.
module assembler_token_scanner #(
    parameter int OFFSET_WIDTH = asmscan_pkg::OFFSET_WIDTH_DEF,
    parameter int LINE_WIDTH   = asmscan_pkg::LINE_WIDTH_DEF,
    parameter int LENGTH_WIDTH = asmscan_pkg::LENGTH_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_char_code,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [asmscan_pkg::KIND_WIDTH-1:0]   o_kind,
    output logic [asmscan_pkg::ERR_WIDTH-1:0]    o_error_code,
    output logic [asmscan_pkg::VALUE_WIDTH-1:0]  o_value,
    output logic [LINE_WIDTH-1:0]                o_line_number,
    output logic [OFFSET_WIDTH-1:0]              o_start_offset,
    output logic [LENGTH_WIDTH-1:0]              o_token_length,
    output logic                                 o_last_of_run
);

    localparam int RES_WIDTH = asmscan_pkg::KIND_WIDTH + asmscan_pkg::ERR_WIDTH
                               + asmscan_pkg::VALUE_WIDTH + LINE_WIDTH
                               + OFFSET_WIDTH + LENGTH_WIDTH + 1;
    localparam int DEPTH     = asmscan_pkg::RESULT_DEPTH;
    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    logic                  accept;
    logic                  busy;
    asmscan_pkg::t_push    push;
    logic [RES_WIDTH-1:0]  res0;
    logic [RES_WIDTH-1:0]  res1;
    logic [RES_WIDTH-1:0]  head;
    logic [CNT_WIDTH-1:0]  fill;
    logic [CNT_WIDTH:0]    claimed;

    assign claimed = {1'b0, fill} + (busy ? (CNT_WIDTH + 1)'(2) : '0)
                     + (CNT_WIDTH + 1)'(2);
    assign o_stall = (claimed > (CNT_WIDTH + 1)'(DEPTH));
    assign accept  = i_valid && !o_stall;

    asmscan_core #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH),
        .RES_WIDTH    (RES_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .o_busy      (busy),
        .o_push      (push),
        .o_res0      (res0),
        .o_res1      (res1)
    );

    asmscan_fifo #(
        .DATA_WIDTH (RES_WIDTH),
        .DEPTH      (DEPTH),
        .CNT_WIDTH  (CNT_WIDTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (res0),
        .i_data1 (res1),
        .i_pop   (o_valid && !i_stall),
        .o_head  (head),
        .o_valid (o_valid),
        .o_count (fill)
    );

    assign {o_kind, o_error_code, o_value, o_line_number, o_start_offset,
            o_token_length, o_last_of_run} = head;

endmodule
